>>> sv/kaa_pkg.sv
package kaa_pkg;

    localparam int MAX_CLUSTERS = 128;
    localparam int MAX_DIMS     = 16;
    localparam int COORD_WIDTH  = 32;
    localparam int CW           = $clog2(MAX_CLUSTERS);
    localparam int DW           = $clog2(MAX_DIMS);
    localparam int AW           = CW + DW;
    localparam int KCW          = CW + 1;
    localparam int DCW          = DW + 1;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_SITE   = 2'd1,
        OP_UPDATE = 2'd2,
        OP_READ   = 2'd3
    } op_t;

    localparam logic [1:0] KIND_LABEL  = 2'd0;
    localparam logic [1:0] KIND_READ   = 2'd1;
    localparam logic [1:0] KIND_UPDATE = 2'd2;

    localparam logic [0:0] CFG_NUM_CLUSTERS = 1'd0;
    localparam logic [0:0] CFG_DIMENSIONS   = 1'd1;

    typedef struct packed {
        logic [1:0]         operation;
        logic [6:0]         cluster_index;
        logic [3:0]         dim_index;
        logic signed [31:0] coord_value;
        logic               last_coord;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         result_kind;
        logic [6:0]         cluster_label;
        logic [63:0]        min_distance;
        logic signed [31:0] centroid_value;
    } out_item_t;

    // divider request / reply
    typedef struct packed {
        logic               start;
        logic signed [63:0] dividend;
        logic [31:0]        divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic signed [COORD_WIDTH-1:0] quotient;
    } div_rsp_t;

endpackage

>>> sv/kmeans_assign_accumulate.sv
// Channel | Ports                         | Transfer
// --------+-------------------------------+--------------------------------
// input   | start, busy, in_item          | edge with start && !busy
// result  | out_valid, out_item           | every cycle out_valid is high
// config  | cfg_we, cfg_index, cfg_data   | edge with cfg_we high
// Write: stored on acceptance. Read: a registered centroid read. Site coordinate: a
// distance pass over the active clusters; the last coordinate adds a nearest search,
// a sum update per received coordinate and the label.
// Update: empty clusters are skipped; each dimension of a nonempty cluster goes
// through the bit-serial divider, then come the result and a clear of the sum and
// count memories; after reset the same clear runs with busy high. One squared
// difference per cycle goes through the shared multiplier. The receiver cannot
// stall; results last one cycle.
module kmeans_assign_accumulate (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  kaa_pkg::in_item_t  in_item,
    output logic               out_valid,
    output kaa_pkg::out_item_t out_item,
    input  logic               cfg_we,
    input  logic [0:0]         cfg_index,
    input  logic [7:0]         cfg_data
);
    import kaa_pkg::*;

    typedef enum logic [13:0] {
        S_CLEAR = 14'b00000000000001,
        S_IDLE  = 14'b00000000000010,
        S_RD    = 14'b00000000000100,
        S_RDOUT = 14'b00000000001000,
        S_DIST  = 14'b00000000010000,
        S_DACC  = 14'b00000000100000,
        S_MIN   = 14'b00000001000000,
        S_SUMRD = 14'b00000010000000,
        S_SUMWR = 14'b00000100000000,
        S_UCNT  = 14'b00001000000000,
        S_UDRD  = 14'b00010000000000,
        S_UDIV  = 14'b00100000000000,
        S_UWAIT = 14'b01000000000000,
        S_LABEL = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [7:0] ncl_reg;
    logic [4:0] dim_reg;
    logic [KCW-1:0] k_act;
    logic [DCW-1:0] d_act;

    // memories
    logic signed [31:0] cen_mem [MAX_CLUSTERS*MAX_DIMS];
    logic signed [63:0] sum_mem [MAX_CLUSTERS*MAX_DIMS];
    logic [31:0]        cnt_mem [MAX_CLUSTERS];
    logic [63:0]        pd_mem  [MAX_CLUSTERS];
    logic signed [31:0] site_mem[MAX_DIMS];

    logic signed [31:0] cen_rd;
    logic signed [63:0] sum_rd;
    logic [31:0]        cnt_rd;
    logic [63:0]        pd_rd;
    logic signed [31:0] site_rd;

    logic        cen_we, sum_we, cnt_we, pd_we;
    logic [AW-1:0] cen_wa, cen_ra, sum_wa, sum_ra;
    logic [CW-1:0] cnt_wa, cnt_ra, pd_wa, pd_ra;
    logic signed [31:0] cen_wd;
    logic signed [63:0] sum_wd;
    logic [31:0] cnt_wd;
    logic [63:0] pd_wd;

    in_item_t        item_reg;
    logic [DW-1:0]   pos_reg, pos_next;
    logic [DW-1:0]   p_reg;
    logic [KCW-1:0]  c_reg, c_next;
    logic [DCW-1:0]  j_reg, j_next;
    logic [AW:0]     clr_reg, clr_next;
    logic [CW-1:0]   best_reg, best_next;
    logic [63:0]     bd_reg, bd_next;
    logic [31:0]     cnt_hold_reg, cnt_hold_next;
    logic            rd_pending_reg, rd_pending_next;
    logic [63:0]     sq_reg;
    logic            sq_valid_reg;
    logic [CW-1:0]   sq_c_reg;
    logic            inrange_reg;
    logic            ends_reg;

    logic signed [32:0] diff;
    logic [31:0]        ad;
    logic [64:0]        pd_sum;
    logic signed [64:0] ssum;
    logic signed [63:0] ssat;

    div_req_t dreq;
    div_rsp_t drsp;

    kaa_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    always_comb
    begin
        k_act = (ncl_reg == 8'd0) ? KCW'(1) :
                (ncl_reg > 8'(MAX_CLUSTERS)) ? KCW'(MAX_CLUSTERS) : KCW'(ncl_reg);
        d_act = (dim_reg == 5'd0) ? DCW'(1) :
                (dim_reg > 5'(MAX_DIMS)) ? DCW'(MAX_DIMS) : DCW'(dim_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ncl_reg <= 8'd1;
            dim_reg <= 5'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_NUM_CLUSTERS: ncl_reg <= cfg_data;
                CFG_DIMENSIONS:   dim_reg <= cfg_data[4:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cen_we) cen_mem[cen_wa] <= cen_wd;
        cen_rd <= cen_mem[cen_ra];
        if (sum_we) sum_mem[sum_wa] <= sum_wd;
        sum_rd <= sum_mem[sum_ra];
        if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
        cnt_rd <= cnt_mem[cnt_ra];
        if (pd_we) pd_mem[pd_wa] <= pd_wd;
        pd_rd <= pd_mem[pd_ra];
        site_rd <= site_mem[j_reg[DW-1:0]];
        if (state_reg == S_IDLE && start && in_item.operation == OP_SITE)
            site_mem[pos_reg] <= in_item.coord_value;
    end

    // shared multiplier: one squared difference per cycle, registered
    always_comb
    begin
        diff = 33'(item_reg.coord_value) - 33'(cen_rd);
        ad   = diff[32] ? 32'(-diff) : diff[31:0];
    end

    always_comb
    begin
        pd_sum = {1'b0, pd_rd} + {1'b0, sq_reg};
        ssum   = 65'(sum_rd) + 65'(site_rd);
        if (ssum > 65'sh0_7FFF_FFFF_FFFF_FFFF)
            ssat = 64'sh7FFF_FFFF_FFFF_FFFF;
        else if (ssum < -65'sh0_8000_0000_0000_0000)
            ssat = 64'sh8000_0000_0000_0000;
        else
            ssat = ssum[63:0];
    end

    always_comb
    begin
        state_next      = state_reg;
        pos_next        = pos_reg;
        c_next          = c_reg;
        j_next          = j_reg;
        clr_next        = clr_reg;
        best_next       = best_reg;
        bd_next         = bd_reg;
        cnt_hold_next   = cnt_hold_reg;
        rd_pending_next = 1'b0;
        cen_we = 1'b0; cen_wa = '0; cen_wd = '0; cen_ra = '0;
        sum_we = 1'b0; sum_wa = '0; sum_wd = '0; sum_ra = '0;
        cnt_we = 1'b0; cnt_wa = '0; cnt_wd = '0; cnt_ra = '0;
        pd_we  = 1'b0; pd_wa  = '0; pd_wd  = '0; pd_ra  = '0;
        dreq   = '0;
        out_valid = 1'b0;
        out_item  = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                sum_we = 1'b1;
                sum_wa = clr_reg[AW-1:0];
                sum_wd = '0;
                cnt_we = (clr_reg < (AW+1)'(MAX_CLUSTERS));
                cnt_wa = clr_reg[CW-1:0];
                cnt_wd = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (AW+1)'(MAX_CLUSTERS*MAX_DIMS - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (in_item.operation)
                        OP_WRITE:
                        begin
                            cen_we = 1'b1;
                            cen_wa = {in_item.cluster_index, in_item.dim_index};
                            cen_wd = in_item.coord_value;
                        end
                        OP_READ:
                        begin
                            cen_ra = {in_item.cluster_index, in_item.dim_index};
                            state_next = S_RDOUT;
                        end
                        OP_SITE:
                        begin
                            c_next = '0;
                            state_next = S_DIST;
                        end
                        OP_UPDATE:
                        begin
                            c_next = '0;
                            state_next = S_UCNT;
                        end
                        default: ;
                    endcase
                end
            end
            S_RD:
                state_next = S_RDOUT;
            S_RDOUT:
            begin
                out_valid = 1'b1;
                out_item.result_kind = KIND_READ;
                out_item.centroid_value = inrange_reg ? cen_rd : 32'sd0;
                state_next = S_IDLE;
            end
            S_DIST:
            begin
                // issue centroid reads for c_reg, retire finished products
                if (c_reg < k_act)
                begin
                    cen_ra = {c_reg[CW-1:0], p_reg};
                    c_next = c_reg + 1'b1;
                    rd_pending_next = 1'b1;
                end
                // partial distance read is issued in the cycle after the centroid read
                if (rd_pending_reg)
                    pd_ra = CW'(c_reg - 1'b1);
                if (sq_valid_reg)
                begin
                    pd_we = 1'b1;
                    pd_wa = sq_c_reg;
                    pd_wd = (p_reg == '0) ? sq_reg :
                            (pd_sum[64] ? {64{1'b1}} : pd_sum[63:0]);
                end
                if (c_reg >= k_act && !rd_pending_reg && !sq_valid_reg)
                begin
                    if (!ends_reg)
                    begin
                        pos_next   = p_reg + 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        c_next = '0;
                        state_next = S_MIN;
                    end
                end
            end
            S_MIN:
            begin
                if (c_reg < k_act)
                begin
                    pd_ra  = c_reg[CW-1:0];
                    c_next = c_reg + 1'b1;
                    rd_pending_next = 1'b1;
                end
                if (rd_pending_reg)
                begin
                    if (c_reg == KCW'(1) || pd_rd < bd_reg)
                    begin
                        bd_next   = pd_rd;
                        best_next = CW'(c_reg - 1'b1);
                    end
                end
                if (c_reg >= k_act && !rd_pending_reg)
                begin
                    cnt_ra = best_reg;
                    j_next = '0;
                    state_next = S_SUMRD;
                end
            end
            S_SUMRD:
            begin
                sum_ra = {best_reg, j_reg[DW-1:0]};
                if (j_reg == '0)
                begin
                    cnt_we = 1'b1;
                    cnt_wa = best_reg;
                    cnt_wd = (cnt_rd == 32'hFFFF_FFFF) ? cnt_rd : cnt_rd + 32'd1;
                end
                state_next = S_SUMWR;
            end
            S_SUMWR:
            begin
                sum_we = 1'b1;
                sum_wa = {best_reg, j_reg[DW-1:0]};
                sum_wd = ssat;
                if (j_reg == DCW'(p_reg))
                begin
                    pos_next   = '0;
                    state_next = S_LABEL;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                    state_next = S_SUMRD;
                end
            end
            S_LABEL:
            begin
                out_valid = 1'b1;
                out_item.result_kind   = KIND_LABEL;
                out_item.cluster_label = 7'(best_reg);
                out_item.min_distance  = bd_reg;
                state_next = S_IDLE;
            end
            S_UCNT:
            begin
                // read count of cluster c_reg, decide next cycle
                cnt_ra = c_reg[CW-1:0];
                j_next = '0;
                if (c_reg >= k_act)
                begin
                    pos_next   = '0;
                    clr_next   = '0;
                    out_valid  = 1'b1;
                    out_item.result_kind = KIND_UPDATE;
                    state_next = S_CLEAR;
                end
                else
                    state_next = S_UDRD;
            end
            S_UDRD:
            begin
                if (j_reg == '0)
                    cnt_hold_next = cnt_rd;
                if (j_reg == '0 && cnt_rd == 32'd0)
                begin
                    c_next = c_reg + 1'b1;
                    state_next = S_UCNT;
                end
                else
                begin
                    sum_ra = {c_reg[CW-1:0], j_reg[DW-1:0]};
                    state_next = S_UDIV;
                end
            end
            S_UDIV:
            begin
                dreq.start    = 1'b1;
                dreq.dividend = sum_rd;
                dreq.divisor  = cnt_hold_reg;
                state_next = S_UWAIT;
            end
            S_UWAIT:
            begin
                if (drsp.done)
                begin
                    cen_we = 1'b1;
                    cen_wa = {c_reg[CW-1:0], j_reg[DW-1:0]};
                    cen_wd = drsp.quotient;
                    if (j_reg + 1'b1 >= d_act)
                    begin
                        c_next = c_reg + 1'b1;
                        state_next = S_UCNT;
                    end
                    else
                    begin
                        j_next = j_reg + 1'b1;
                        state_next = S_UDRD;
                    end
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // the UCNT message fires in the same cycle that leaves for the clear pass
    assign busy = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            pos_reg        <= '0;
            c_reg          <= '0;
            j_reg          <= '0;
            clr_reg        <= '0;
            rd_pending_reg <= 1'b0;
            sq_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pos_reg        <= pos_next;
            c_reg          <= c_next;
            j_reg          <= j_next;
            clr_reg        <= clr_next;
            rd_pending_reg <= rd_pending_next;
            sq_valid_reg   <= rd_pending_reg && (state_reg == S_DIST);
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg     <= best_next;
        bd_reg       <= bd_next;
        cnt_hold_reg <= cnt_hold_next;
        sq_reg       <= 64'(ad) * 64'(ad);
        sq_c_reg     <= CW'(c_reg - 1'b1);
        if (state_reg == S_IDLE && start)
        begin
            item_reg    <= in_item;
            inrange_reg <= 1'b1;
            p_reg       <= pos_reg;
            ends_reg    <= in_item.last_coord || (DCW'(pos_reg) + 1'b1 >= d_act);
        end
    end

endmodule

>>> sv/kaa_divider.sv
module kaa_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  kaa_pkg::div_req_t req,
    output kaa_pkg::div_rsp_t rsp
);
    import kaa_pkg::*;

    logic [63:0] rem_reg, rem_next;
    logic [63:0] quo_reg, quo_next;
    logic [31:0] dvs_reg, dvs_next;
    logic        neg_reg, neg_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [64:0] trial;
    logic [63:0] shifted;
    logic [63:0] mag;
    logic signed [64:0] sq;
    logic signed [COORD_WIDTH-1:0] qsat;

    localparam logic signed [64:0] QHI = 65'sd2 ** (COORD_WIDTH - 1) - 65'sd1;
    localparam logic signed [64:0] QLO = -(65'sd2 ** (COORD_WIDTH - 1));

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        mag       = req.dividend[63] ? 64'(-req.dividend) : 64'(req.dividend);
        shifted   = {rem_reg[62:0], quo_reg[63]};
        trial     = {1'b0, shifted} - {33'd0, dvs_reg};
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = mag;
            dvs_next  = req.divisor;
            neg_next  = req.dividend[63];
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // one quotient bit per cycle
            if (!trial[64])
            begin
                rem_next = trial[63:0];
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        sq = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
        if (sq > QHI)
            qsat = QHI[COORD_WIDTH-1:0];
        else if (sq < QLO)
            qsat = QLO[COORD_WIDTH-1:0];
        else
            qsat = sq[COORD_WIDTH-1:0];
        rsp.done     = done_reg;
        rsp.quotient = qsat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

endmodule
